>>> rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MSD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MSD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/msd_pkg.sv
package msd_pkg;
    localparam int FACE_SLOTS = 4;
    localparam int SLOT_W = 2;
    localparam int ADDR_W = (FACE_SLOTS > 1) ? $clog2(FACE_SLOTS) : 1;
    localparam int COORD_W = 18;
    localparam int RATIO_W = 18;
    localparam int CNT_W = 8;
    localparam int SQ_W = 38;
    localparam int ROOT_W = 19;
    localparam int QUO_W = 35;
    localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [1:0] MODE_FACE = 2'd0;
    localparam logic [1:0] MODE_MISSING = 2'd2;

    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_STARTED = 2'd1;
    localparam logic [1:0] EV_STOP_CLOSED = 2'd2;
    localparam logic [1:0] EV_STOP_MISSING = 2'd3;

    localparam logic [1:0] REG_START_RATIO = 2'd0;
    localparam logic [1:0] REG_STOP_RATIO = 2'd1;
    localparam logic [1:0] REG_START_CONFIRM = 2'd2;
    localparam logic [1:0] REG_STOP_CONFIRM = 2'd3;

    localparam logic [RATIO_W-1:0] START_RATIO_RST = 18'd2949;
    localparam logic [RATIO_W-1:0] STOP_RATIO_RST = 18'd1966;
    localparam logic [CNT_W-1:0] START_CONFIRM_RST = 8'd2;
    localparam logic [CNT_W-1:0] STOP_CONFIRM_RST = 8'd5;

    typedef struct packed {
        logic                speaking;
        logic [CNT_W-1:0]    open_run;
        logic [CNT_W-1:0]    closed_run;
        logic [CNT_W-1:0]    missing_run;
        logic [RATIO_W-1:0]  last_ratio;
        logic                last_valid;
    } face_state_t;

    localparam int STATE_W = $bits(face_state_t);

    typedef struct packed {
        logic [RATIO_W-1:0] start_ratio;
        logic [RATIO_W-1:0] stop_ratio;
        logic [CNT_W-1:0]   start_confirm;
        logic [CNT_W-1:0]   stop_confirm;
    } msd_cfg_t;
endpackage

>>> rtl/msd_ram.sv
module msd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/msd_ratio.sv
// Computes the open ratio: two square roots and one restoring divide, shared
// over cycles; start pulses the unit, done pulses when ratio is ready.
module msd_ratio (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [msd_pkg::SQ_W-1:0]     gap_sq,
    input  logic [msd_pkg::SQ_W-1:0]     wid_sq,
    output logic                         done,
    output logic [msd_pkg::RATIO_W-1:0]  ratio
);
    import msd_pkg::*;

    typedef enum logic [3:0] {
        R_IDLE = 4'b0001,
        R_SQG  = 4'b0010,
        R_SQW  = 4'b0100,
        R_DIV  = 4'b1000
    } rstate_t;

    rstate_t            st_reg, st_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [SQ_W-1:0]    rem_reg, rem_next;
    logic [SQ_W-1:0]    val_reg, val_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [ROOT_W-1:0]  gap_reg, gap_next;
    logic [SQ_W-1:0]    wsq_reg, wsq_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [ROOT_W:0]    drem_reg, drem_next;
    logic [ROOT_W-1:0]  div_reg, div_next;
    logic               done_reg, done_next;

    logic [ROOT_W+1:0]  trial;
    logic [SQ_W-1:0]    rem_sh;
    logic [ROOT_W:0]    dsh;
    logic [ROOT_W:0]    dsub;
    logic [QUO_W-1:0]   num;

    always_comb begin
        st_next = st_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        val_next = val_reg;
        root_next = root_reg;
        gap_next = gap_reg;
        wsq_next = wsq_reg;
        quo_next = quo_reg;
        drem_next = drem_reg;
        div_next = div_reg;
        done_next = 1'b0;
        // One radix-2 square-root step: bring down two bits, try 4r+1.
        rem_sh = {rem_reg[SQ_W-3:0], val_reg[SQ_W-1:SQ_W-2]};
        trial = {root_reg, 2'b01};
        num = {gap_reg, 16'd0};
        dsh = {drem_reg[ROOT_W-1:0], num[QUO_W-1-cnt_reg]};
        dsub = dsh - {1'b0, div_reg};
        case (st_reg)
            R_IDLE: begin
                if (start) begin
                    st_next = R_SQG;
                    cnt_next = '0;
                    rem_next = '0;
                    root_next = '0;
                    val_next = gap_sq;
                    wsq_next = wid_sq;
                end
            end
            R_SQG, R_SQW: begin
                val_next = {val_reg[SQ_W-3:0], 2'b00};
                if ({{(SQ_W-ROOT_W-2){1'b0}}, trial} <= rem_sh) begin
                    rem_next = rem_sh - {{(SQ_W-ROOT_W-2){1'b0}}, trial};
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(ROOT_W - 1)) begin
                    // The finished root is taken before the step registers clear.
                    if (st_reg == R_SQG) begin
                        gap_next = root_next;
                        val_next = wsq_reg;
                        st_next = R_SQW;
                    end else begin
                        div_next = (root_next == '0) ? ROOT_W'(1) : root_next;
                        drem_next = '0;
                        quo_next = '0;
                        st_next = R_DIV;
                    end
                    cnt_next = '0;
                    rem_next = '0;
                    root_next = '0;
                end
            end
            R_DIV: begin
                if (!dsub[ROOT_W]) begin
                    drem_next = dsub;
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end else begin
                    drem_next = dsh;
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(QUO_W - 1)) begin
                    st_next = R_IDLE;
                    done_next = 1'b1;
                end
            end
            default: st_next = R_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= R_IDLE;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            st_reg <= st_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        val_reg <= val_next;
        root_reg <= root_next;
        gap_reg <= gap_next;
        wsq_reg <= wsq_next;
        quo_reg <= quo_next;
        drem_reg <= drem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign ratio = (quo_reg > QUO_W'(RATIO_MAX)) ? RATIO_MAX : quo_reg[RATIO_W-1:0];
endmodule

>>> rtl/mouth_speaking_detector.sv
// Items are handled one at a time; for a face with landmarks the result also
// waits on two 19-step square roots and a 35-step divide, one step a cycle.
// The next input is taken once the sequencer is idle and the result register
// is free. Reset is synchronous, active low; after it a clearing pass zeroes
// the state of every face slot first.
`include "assert_macros.svh"
module mouth_speaking_detector (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: face_slot[1:0], upper_x, upper_y, lower_x, lower_y, corner_left_x,
    // corner_left_y, corner_right_x, corner_right_y (18 bits each), zero pad.
    input  logic [151:0] s_tdata,
    // tuser: mode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: slot_out[1:0], available, ratio[17:0], motion[17:0],
    // speaking, event_res[1:0], zero pad to 48 bits.
    output logic [47:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import msd_pkg::*;

    // Sequencer: one-hot states clear the slots after reset, then walk an item through read, compute, write and output.
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_CALC  = 6'b001000,
        S_UPD   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t                st_reg, st_next;
    msd_cfg_t              cfg_reg;
    logic [ADDR_W:0]       clr_reg, clr_next;
    logic [1:0]            mode_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  inrange_reg;
    logic [SQ_W-1:0]       gsq_reg, wsq_reg;
    logic [RATIO_W-1:0]    ratio_reg;
    logic                  out_valid_reg;
    logic [41:0]           out_reg;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    face_state_t           ram_wdata, ram_rdata, fs_reg, nst;
    logic                  calc_start, calc_done;
    logic [RATIO_W-1:0]    calc_ratio;
    logic                  s_fire;
    logic [RATIO_W-1:0]    r, motion;
    logic [1:0]            ev;
    logic [CNT_W-1:0]      sc, pc, oi, ci, mi;
    logic                  avail;

    // Squared distances: the four 38-bit products are formed in the cycle after
    // capture, each a single 19x19 multiply registered before the sum.
    logic signed [COORD_W:0] gdx, gdy, wdx, wdy;
    logic [SQ_W-1:0]         gx2_reg, gy2_reg, wx2_reg, wy2_reg;

    assign s_fire = s_tvalid && s_tready;
    assign s_tready = (st_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{START_RATIO_RST, STOP_RATIO_RST, START_CONFIRM_RST,
                         STOP_CONFIRM_RST};
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_START_RATIO:   cfg_reg.start_ratio <= cfg_data[RATIO_W-1:0];
                REG_STOP_RATIO:    cfg_reg.stop_ratio <= cfg_data[RATIO_W-1:0];
                REG_START_CONFIRM: cfg_reg.start_confirm <= cfg_data[CNT_W-1:0];
                REG_STOP_CONFIRM:  cfg_reg.stop_confirm <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            mode_reg <= s_tuser;
            slot_reg <= s_tdata[1:0];
            inrange_reg <= ({1'b0, s_tdata[1:0]} < 3'(FACE_SLOTS));
        end
    end

    // Landmark differences are taken straight from the captured input bits.
    logic [151:0] pin_reg;
    always_ff @(posedge aclk) begin
        if (s_fire) pin_reg <= s_tdata;
    end
    assign gdx = $signed({pin_reg[19], pin_reg[19:2]}) - $signed({pin_reg[55], pin_reg[55:38]});
    assign gdy = $signed({pin_reg[37], pin_reg[37:20]}) - $signed({pin_reg[73], pin_reg[73:56]});
    assign wdx = $signed({pin_reg[91], pin_reg[91:74]})
               - $signed({pin_reg[127], pin_reg[127:110]});
    assign wdy = $signed({pin_reg[109], pin_reg[109:92]})
               - $signed({pin_reg[145], pin_reg[145:128]});

    function automatic logic [SQ_W-1:0] sq(input logic signed [COORD_W:0] d);
        logic [COORD_W:0] a;
        a = d[COORD_W] ? (COORD_W + 1)'(-d) : (COORD_W + 1)'(d);
        return SQ_W'(a) * SQ_W'(a);
    endfunction

    always_ff @(posedge aclk) begin
        gx2_reg <= sq(gdx);
        gy2_reg <= sq(gdy);
        wx2_reg <= sq(wdx);
        wy2_reg <= sq(wdy);
        gsq_reg <= gx2_reg + gy2_reg;
        wsq_reg <= wx2_reg + wy2_reg;
    end

    msd_ratio u_ratio (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (calc_start),
        .gap_sq  (gsq_reg),
        .wid_sq  (wsq_reg),
        .done    (calc_done),
        .ratio   (calc_ratio)
    );

    msd_ram #(.WIDTH(STATE_W), .DEPTH(1 << ADDR_W)) u_state (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (slot_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // READ holds until the registered RAM word has arrived and the squared sums,
    // formed from the registered squares, are registered too.
    logic [1:0] rd_cnt_reg;
    assign calc_start = (st_reg == S_READ) && (rd_cnt_reg == 2'd2)
                        && (mode_reg == MODE_FACE) && inrange_reg;

    always_comb begin
        st_next = st_reg;
        clr_next = clr_reg;
        case (st_reg)
            S_CLEAR: begin
                clr_next = clr_reg + (ADDR_W + 1)'(1);
                if (clr_reg == (ADDR_W + 1)'(FACE_SLOTS - 1)) st_next = S_IDLE;
            end
            S_IDLE: if (s_fire) st_next = S_READ;
            S_READ: begin
                if (rd_cnt_reg == 2'd2) st_next = calc_start ? S_CALC : S_UPD;
            end
            S_CALC: if (calc_done) st_next = S_UPD;
            S_UPD:  st_next = S_OUT;
            S_OUT:  st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_CLEAR;
            clr_reg <= '0;
            rd_cnt_reg <= '0;
        end else begin
            st_reg <= st_next;
            clr_reg <= clr_next;
            rd_cnt_reg <= (st_reg == S_READ) ? rd_cnt_reg + 2'd1 : 2'd0;
        end
        if (st_reg == S_READ) fs_reg <= ram_rdata;
        if (calc_done) ratio_reg <= calc_ratio;
        else if (st_reg == S_READ) ratio_reg <= '0;
    end

    // State update for the slot, following the hysteresis rules.
    always_comb begin
        sc = (cfg_reg.start_confirm == '0) ? CNT_W'(1) : cfg_reg.start_confirm;
        pc = (cfg_reg.stop_confirm == '0) ? CNT_W'(1) : cfg_reg.stop_confirm;
        nst = fs_reg;
        ev = EV_NONE;
        avail = 1'b0;
        r = ratio_reg;
        motion = '0;
        oi = (fs_reg.open_run == CNT_MAX) ? CNT_MAX : fs_reg.open_run + CNT_W'(1);
        ci = (fs_reg.closed_run == CNT_MAX) ? CNT_MAX : fs_reg.closed_run + CNT_W'(1);
        mi = (fs_reg.missing_run == CNT_MAX) ? CNT_MAX : fs_reg.missing_run + CNT_W'(1);
        if (inrange_reg && mode_reg == MODE_FACE) begin
            avail = 1'b1;
            if (fs_reg.last_valid) begin
                motion = (r >= fs_reg.last_ratio) ? r - fs_reg.last_ratio
                                                  : fs_reg.last_ratio - r;
            end
            nst.last_ratio = r;
            nst.last_valid = 1'b1;
            nst.missing_run = '0;
            if (!fs_reg.speaking) begin
                nst.closed_run = '0;
                nst.open_run = (r >= cfg_reg.start_ratio) ? oi : '0;
                if (nst.open_run >= sc) begin
                    nst.speaking = 1'b1;
                    nst.open_run = '0;
                    ev = EV_STARTED;
                end
            end else begin
                nst.open_run = '0;
                nst.closed_run = (r <= cfg_reg.stop_ratio) ? ci : '0;
                if (nst.closed_run >= pc) begin
                    nst.speaking = 1'b0;
                    nst.closed_run = '0;
                    ev = EV_STOP_CLOSED;
                end
            end
        end else if (inrange_reg && mode_reg == MODE_MISSING && fs_reg.speaking) begin
            nst.missing_run = mi;
            if (mi >= pc) begin
                nst = '0;
                nst.last_ratio = fs_reg.last_ratio;
                ev = EV_STOP_MISSING;
            end
        end
    end

    assign ram_we = (st_reg == S_CLEAR) || (st_reg == S_UPD && inrange_reg);
    assign ram_waddr = (st_reg == S_CLEAR) ? clr_reg[ADDR_W-1:0] : slot_reg[ADDR_W-1:0];
    assign ram_wdata = (st_reg == S_CLEAR) ? face_state_t'('0) : nst;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (st_reg == S_UPD) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (st_reg == S_UPD) begin
            out_reg <= {ev, inrange_reg & nst.speaking, avail ? motion : RATIO_W'(0),
                        avail ? r : RATIO_W'(0), avail, slot_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {6'd0, out_reg};

    `MSD_ASSERT_IMP(a_no_in_while_busy, aclk, aresetn, st_reg != S_IDLE, !s_tready)
    `MSD_ASSERT_NXT(a_upd_gives_out, aclk, aresetn, st_reg == S_UPD, m_tvalid)
    `MSD_ASSERT_IMP(a_clear_no_in, aclk, aresetn, st_reg == S_CLEAR, !m_tvalid)
endmodule
